// ===== hdl/kti_pkg.sv =====
package kti_pkg;

    localparam int ENTRIES     = 64;
    localparam int ENTRY_W     = $clog2(ENTRIES);
    localparam int POINTS      = 4;
    localparam int POINT_W     = 2;
    localparam int COORD_W     = 32;
    localparam int ANGLE_W     = 16;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 7;
    localparam int FRAC_W      = 16;
    localparam int DIV_STEPS   = FRAC_W;
    localparam int AXIS_W      = 2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [POINT_W-1:0] PT_PAYLOAD    = 2'd0;
    localparam logic [POINT_W-1:0] PT_REAR_RIGHT = 2'd3;

    localparam logic [AXIS_W-1:0] AXIS_X     = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z     = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_ANGLE = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_EDGE,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_TA_RD,
        ST_TA_CK,
        ST_DIV_SET,
        ST_DIV,
        ST_AF_A,
        ST_AF_B,
        ST_AF_C,
        ST_PT_A,
        ST_PT_B,
        ST_PT_C,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/kti_ram.sv =====
module kti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/keyframe_trajectory_interpolator.sv =====
// Keyframe trajectory interpolator.
// Input channel s_*: a write request (tuser action 0) stores one point of a
// keyframe; a payload write also stores time, pitch and the drone flag. A
// write is taken only while idle and gives no result. A query request (action 1)
// looks the trajectory up at tdata time and gives four results on m_*,
// payload, front, rear left, rear right, the fourth with tlast set.
// A query scans keyframes through the single time memory port and runs the
// bit-serial divider, both only when needed, then computes each result in
// the shared multiply-add unit. s_tready is high only while no query is in
// work. Each result waits in the output register until m_tready; the
// sequencer holds meanwhile, so a stall on m_* stalls s_* too.
// cfg_wr_en writes sample_count (reset 2); the user must do so only while
// idle, the block does not enforce it. aresetn (synchronous, active low)
// returns to idle with no result pending; keyframe memory is not cleared
// and must be written before it is queried.
module keyframe_trajectory_interpolator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, time_value, coord_x, coord_y, coord_z, pitch_angle,
    // drones_present, zero pad
    input  logic [151:0] s_tdata,
    // action, point_select
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, out_angle
    output logic [111:0] m_tdata,
    // out_point, drones_valid
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int CA_W = kti_pkg::ENTRY_W + kti_pkg::POINT_W;
    localparam int CV_W = 3 * kti_pkg::COORD_W;

    kti_pkg::state_t state_reg, state_next;

    logic [kti_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [kti_pkg::COUNT_W-1:0] n_reg, n_next;
    logic [kti_pkg::TIME_W-1:0]  t_reg, t_next;
    logic [kti_pkg::TIME_W-1:0]  t0_reg, t0_next;
    logic [kti_pkg::TIME_W-1:0]  ta_reg, ta_next;
    logic [kti_pkg::TIME_W-1:0]  tb_reg, tb_next;
    logic [kti_pkg::ENTRY_W-1:0] ea_reg, ea_next;
    logic [kti_pkg::ENTRY_W-1:0] eb_reg, eb_next;
    logic signed [32:0]          rem_reg, rem_next;
    logic signed [32:0]          dt_reg, dt_next;
    logic [16:0]                 u_reg, u_next;
    logic [3:0]                  step_reg, step_next;
    logic [15:0]                 ang_a_reg, ang_a_next;
    logic [15:0]                 ang_b_reg, ang_b_next;
    logic                        flag_a_reg, flag_a_next;
    logic                        valid_reg, valid_next;
    logic [1:0]                  pt_reg, pt_next;
    logic [1:0]                  axis_reg, axis_next;
    logic [CV_W-1:0]             ca_reg, ca_next;
    logic [CV_W-1:0]             cb_reg, cb_next;
    logic signed [50:0]          prod_reg, prod_next;
    logic [31:0]                 rx_reg, rx_next;
    logic [31:0]                 ry_reg, ry_next;
    logic [31:0]                 rz_reg, rz_next;
    logic [15:0]                 rang_reg, rang_next;

    logic                        accept;
    logic                        is_write;
    logic [kti_pkg::ENTRY_W-1:0] ent_addr;
    logic [CA_W-1:0]             coord_addr;
    logic [31:0]                 time_dout;
    logic [16:0]                 af_dout;
    logic [CV_W-1:0]             coord_dout;

    logic [kti_pkg::ENTRY_W-1:0] last_entry;
    logic signed [32:0]          dt_raw, dt_clamp, num_raw;
    logic [33:0]                 rem2;
    logic [33:0]                 dt_ext;
    logic signed [32:0]          base_a, base_b, delta;
    logic [15:0]                 ang_diff;
    logic signed [16:0]          ang_delta;
    logic signed [34:0]          scaled;
    logic signed [34:0]          sum;
    logic                        zero_pt;

    assign accept   = s_tvalid && s_tready;
    assign is_write = accept && (s_tuser[0] == kti_pkg::ACT_WRITE);

    kti_ram #(.WIDTH(32), .DEPTH(kti_pkg::ENTRIES)) u_time_ram (
        .aclk  (aclk),
        .we    (is_write && (s_tuser[2:1] == kti_pkg::PT_PAYLOAD)),
        .addr  (ent_addr),
        .wdata (s_tdata[37:6]),
        .rdata (time_dout)
    );

    kti_ram #(.WIDTH(17), .DEPTH(kti_pkg::ENTRIES)) u_af_ram (
        .aclk  (aclk),
        .we    (is_write && (s_tuser[2:1] == kti_pkg::PT_PAYLOAD)),
        .addr  (ent_addr),
        .wdata ({s_tdata[150], s_tdata[149:134]}),
        .rdata (af_dout)
    );

    kti_ram #(.WIDTH(CV_W), .DEPTH(kti_pkg::ENTRIES * kti_pkg::POINTS)) u_coord_ram (
        .aclk  (aclk),
        .we    (is_write),
        .addr  (coord_addr),
        .wdata (s_tdata[133:38]),
        .rdata (coord_dout)
    );

    assign last_entry = kti_pkg::ENTRY_W'(n_reg - 7'd1);
    assign dt_raw     = $signed({1'b0, tb_reg}) - $signed({1'b0, ta_reg});
    assign num_raw    = $signed({1'b0, t_reg}) - $signed({1'b0, ta_reg});
    assign dt_clamp   = (dt_raw < 33'sd1) ? 33'sd1 : dt_raw;
    assign rem2       = {rem_reg, 1'b0};
    assign dt_ext     = {1'b0, dt_reg};
    assign ang_diff   = ang_b_reg - ang_a_reg;
    assign ang_delta  = (ang_diff > 16'd32768) ? {1'b1, ang_diff} : {1'b0, ang_diff};

    always_comb begin
        case (axis_reg)
            kti_pkg::AXIS_X: begin
                base_a = {ca_reg[31], ca_reg[31:0]};
                base_b = {cb_reg[31], cb_reg[31:0]};
            end
            kti_pkg::AXIS_Y: begin
                base_a = {ca_reg[63], ca_reg[63:32]};
                base_b = {cb_reg[63], cb_reg[63:32]};
            end
            kti_pkg::AXIS_Z: begin
                base_a = {ca_reg[95], ca_reg[95:64]};
                base_b = {cb_reg[95], cb_reg[95:64]};
            end
            default: begin
                base_a = {17'd0, ang_a_reg};
                base_b = 33'sd0;
            end
        endcase
    end

    assign delta  = (axis_reg == kti_pkg::AXIS_ANGLE) ? 33'(ang_delta) : base_b - base_a;
    assign scaled = 35'(prod_reg >>> kti_pkg::FRAC_W);
    assign sum    = 35'(base_a) + scaled;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kti_pkg::ST_IDLE;
            count_reg <= kti_pkg::COUNT_MIN;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        n_reg      <= n_next;
        t_reg      <= t_next;
        t0_reg     <= t0_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        rem_reg    <= rem_next;
        dt_reg     <= dt_next;
        u_reg      <= u_next;
        step_reg   <= step_next;
        ang_a_reg  <= ang_a_next;
        ang_b_reg  <= ang_b_next;
        flag_a_reg <= flag_a_next;
        valid_reg  <= valid_next;
        pt_reg     <= pt_next;
        axis_reg   <= axis_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        prod_reg   <= prod_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        rz_reg     <= rz_next;
        rang_reg   <= rang_next;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = cfg_wr_en ? cfg_wr_data : count_reg;
        n_next      = n_reg;
        t_next      = t_reg;
        t0_next     = t0_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        rem_next    = rem_reg;
        dt_next     = dt_reg;
        u_next      = u_reg;
        step_next   = step_reg;
        ang_a_next  = ang_a_reg;
        ang_b_next  = ang_b_reg;
        flag_a_next = flag_a_reg;
        valid_next  = valid_reg;
        pt_next     = pt_reg;
        axis_next   = axis_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        prod_next   = prod_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        rz_next     = rz_reg;
        rang_next   = rang_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        ent_addr    = s_tdata[5:0];
        coord_addr  = {s_tdata[5:0], s_tuser[2:1]};

        case (state_reg)
            kti_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept && (s_tuser[0] == kti_pkg::ACT_QUERY)) begin
                    t_next = s_tdata[37:6];
                    if (count_reg < kti_pkg::COUNT_MIN) begin
                        n_next = kti_pkg::COUNT_MIN;
                    end else if (count_reg > kti_pkg::COUNT_MAX) begin
                        n_next = kti_pkg::COUNT_MAX;
                    end else begin
                        n_next = count_reg;
                    end
                    state_next = kti_pkg::ST_FIRST;
                end
            end
            kti_pkg::ST_FIRST: begin
                ent_addr   = '0;
                state_next = kti_pkg::ST_LAST;
            end
            kti_pkg::ST_LAST: begin
                ent_addr   = last_entry;
                t0_next    = time_dout;
                state_next = kti_pkg::ST_EDGE;
            end
            kti_pkg::ST_EDGE: begin
                u_next = '0;
                if (t_reg <= t0_reg) begin
                    ea_next    = '0;
                    eb_next    = '0;
                    state_next = kti_pkg::ST_AF_A;
                end else if (t_reg >= time_dout) begin
                    ea_next    = last_entry;
                    eb_next    = last_entry;
                    state_next = kti_pkg::ST_AF_A;
                end else begin
                    eb_next    = kti_pkg::ENTRY_W'(1);
                    state_next = kti_pkg::ST_SCAN_RD;
                end
            end
            kti_pkg::ST_SCAN_RD: begin
                ent_addr   = eb_reg;
                state_next = kti_pkg::ST_SCAN_CK;
            end
            kti_pkg::ST_SCAN_CK: begin
                if ((eb_reg < last_entry) && (time_dout < t_reg)) begin
                    eb_next    = eb_reg + 1'b1;
                    state_next = kti_pkg::ST_SCAN_RD;
                end else begin
                    tb_next    = time_dout;
                    ea_next    = eb_reg - 1'b1;
                    state_next = kti_pkg::ST_TA_RD;
                end
            end
            kti_pkg::ST_TA_RD: begin
                ent_addr   = ea_reg;
                state_next = kti_pkg::ST_TA_CK;
            end
            kti_pkg::ST_TA_CK: begin
                ta_next    = time_dout;
                state_next = kti_pkg::ST_DIV_SET;
            end
            kti_pkg::ST_DIV_SET: begin
                dt_next   = dt_clamp;
                rem_next  = num_raw;
                step_next = '0;
                if (num_raw <= 33'sd0) begin
                    u_next     = '0;
                    state_next = kti_pkg::ST_AF_A;
                end else if (num_raw >= dt_clamp) begin
                    u_next     = 17'h10000;
                    state_next = kti_pkg::ST_AF_A;
                end else begin
                    u_next     = '0;
                    state_next = kti_pkg::ST_DIV;
                end
            end
            kti_pkg::ST_DIV: begin
                if (rem2 >= dt_ext) begin
                    rem_next = $signed(33'(rem2 - dt_ext));
                    u_next   = {1'b0, u_reg[14:0], 1'b1};
                end else begin
                    rem_next = $signed(rem2[32:0]);
                    u_next   = {1'b0, u_reg[14:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 4'(kti_pkg::DIV_STEPS - 1)) begin
                    state_next = kti_pkg::ST_AF_A;
                end
            end
            kti_pkg::ST_AF_A: begin
                ent_addr   = ea_reg;
                state_next = kti_pkg::ST_AF_B;
            end
            kti_pkg::ST_AF_B: begin
                ent_addr    = eb_reg;
                ang_a_next  = af_dout[15:0];
                flag_a_next = af_dout[16];
                state_next  = kti_pkg::ST_AF_C;
            end
            kti_pkg::ST_AF_C: begin
                ang_b_next = af_dout[15:0];
                valid_next = flag_a_reg && af_dout[16];
                pt_next    = kti_pkg::PT_PAYLOAD;
                state_next = kti_pkg::ST_PT_A;
            end
            kti_pkg::ST_PT_A: begin
                coord_addr = {ea_reg, pt_reg};
                state_next = kti_pkg::ST_PT_B;
            end
            kti_pkg::ST_PT_B: begin
                coord_addr = {eb_reg, pt_reg};
                ca_next    = coord_dout;
                state_next = kti_pkg::ST_PT_C;
            end
            kti_pkg::ST_PT_C: begin
                cb_next    = coord_dout;
                axis_next  = kti_pkg::AXIS_X;
                state_next = kti_pkg::ST_MUL;
            end
            kti_pkg::ST_MUL: begin
                prod_next  = $signed({1'b0, u_reg}) * delta;
                state_next = kti_pkg::ST_ADD;
            end
            kti_pkg::ST_ADD: begin
                case (axis_reg)
                    kti_pkg::AXIS_X: rx_next = sum[31:0];
                    kti_pkg::AXIS_Y: ry_next = sum[31:0];
                    kti_pkg::AXIS_Z: rz_next = sum[31:0];
                    default:         rang_next = sum[15:0];
                endcase
                if ((axis_reg == kti_pkg::AXIS_ANGLE) ||
                    ((axis_reg == kti_pkg::AXIS_Z) && (pt_reg != kti_pkg::PT_PAYLOAD))) begin
                    state_next = kti_pkg::ST_OUT;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = kti_pkg::ST_MUL;
                end
            end
            kti_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (pt_reg == kti_pkg::PT_REAR_RIGHT) begin
                        state_next = kti_pkg::ST_IDLE;
                    end else begin
                        pt_next    = pt_reg + 1'b1;
                        state_next = kti_pkg::ST_PT_A;
                    end
                end
            end
            default: begin
                state_next = kti_pkg::ST_IDLE;
            end
        endcase
    end

    assign zero_pt = (pt_reg != kti_pkg::PT_PAYLOAD) && !valid_reg;
    assign m_tdata = {
        (pt_reg == kti_pkg::PT_PAYLOAD) ? rang_reg : 16'd0,
        zero_pt ? 32'd0 : rz_reg,
        zero_pt ? 32'd0 : ry_reg,
        zero_pt ? 32'd0 : rx_reg
    };
    assign m_tuser = {valid_reg, pt_reg};
    assign m_tlast = (pt_reg == kti_pkg::PT_REAR_RIGHT);

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (state_reg == kti_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after the last result");

    a_u_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kti_pkg::ST_MUL) |-> (u_reg <= 17'h10000))
        else $error("interpolation fraction out of range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
        else $error("pending result dropped");

endmodule

// ===== tb/sv/tb.sv =====
module tb;

    typedef struct {
        logic              act;
        logic [5:0]        entry;
        logic [1:0]        pt;
        logic [31:0]       tval;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       z;
        logic [15:0]       ang;
        logic              dp;
        bit                typed;
        logic [31:0]       tx;
        logic [15:0]       tang;
    } request_t;

    typedef struct {
        logic [1:0]  pt;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] ang;
        logic        dv;
        logic        last;
    } sample_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [6:0]   cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    keyframe_trajectory_interpolator uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    logic [31:0]       kf_time [kti_pkg::ENTRIES];
    logic [15:0]       kf_angle [kti_pkg::ENTRIES];
    logic              kf_flag [kti_pkg::ENTRIES];
    logic [31:0]       kf_coord [kti_pkg::ENTRIES][kti_pkg::POINTS][3];
    bit                kf_written [kti_pkg::ENTRIES][kti_pkg::POINTS];
    logic [6:0]        sample_count;
    sample_t           exp_q [64];
    int                exp_wr;
    int                exp_rd;
    int                errors;
    int                queries_done;
    int                writes_done;
    int                settings_done;
    bit                no_stall;
    int                stall_left;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    initial begin
        #10000000;
        $display("timeout waiting for results");
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h (query %0d)", what, got, want, queries_done);
        errors++;
    endtask

    function automatic int pending();
        return exp_wr - exp_rd;
    endfunction

    function automatic void queue_sample(sample_t s);
        exp_q[exp_wr % 64] = s;
        exp_wr++;
    endfunction

    function automatic int count_in_use();
        if (sample_count < kti_pkg::COUNT_MIN) return 2;
        if (sample_count > kti_pkg::COUNT_MAX) return kti_pkg::ENTRIES;
        return int'(sample_count);
    endfunction

    // floor(u * d / 2^16) via arithmetic shift
    function automatic longint lerp_step(longint u, longint d);
        longint p;
        p = u * d;
        return p >>> kti_pkg::FRAC_W;
    endfunction

    function automatic void apply_request(request_t r);
        sample_t s;
        int n, ea, eb, e;
        longint span, num, u, d, a, b;
        logic [15:0] ang;
        logic dv;
        if (r.act == kti_pkg::ACT_WRITE) begin
            for (int c = 0; c < 3; c++)
                kf_coord[r.entry][r.pt][c] = (c == 0) ? r.x : (c == 1) ? r.y : r.z;
            kf_written[r.entry][r.pt] = 1'b1;
            if (r.pt == kti_pkg::PT_PAYLOAD) begin
                kf_time[r.entry] = r.tval;
                kf_angle[r.entry] = r.ang;
                kf_flag[r.entry] = r.dp;
            end
            writes_done++;
            return;
        end
        n = count_in_use();
        queries_done++;
        if (r.tval <= kf_time[0] || r.tval >= kf_time[n-1]) begin
            e = (r.tval <= kf_time[0]) ? 0 : n - 1;
            dv = kf_flag[e];
            for (int p = 0; p < kti_pkg::POINTS; p++) begin
                s.pt = 2'(p);
                s.x = (p == 0 || dv) ? kf_coord[e][p][0] : '0;
                s.y = (p == 0 || dv) ? kf_coord[e][p][1] : '0;
                s.z = (p == 0 || dv) ? kf_coord[e][p][2] : '0;
                s.ang = (p == 0) ? kf_angle[e] : '0;
                s.dv = dv;
                s.last = (p == kti_pkg::POINTS - 1);
                if (p == 0 && r.typed) begin
                    s.x = r.tx;
                    s.ang = r.tang;
                end
                queue_sample(s);
            end
            return;
        end
        eb = 1;
        while (eb < n - 1 && kf_time[eb] < r.tval) eb++;
        ea = eb - 1;
        span = longint'(kf_time[eb]) - longint'(kf_time[ea]);
        num = longint'(r.tval) - longint'(kf_time[ea]);
        if (span < 1) span = 1;
        if (num <= 0) u = 0;
        else if (num >= span) u = 65536;
        else u = (num * 65536) / span;
        dv = kf_flag[ea] & kf_flag[eb];
        d = longint'(16'(kf_angle[eb] - kf_angle[ea]));
        if (d > 32768) d -= 65536;
        ang = 16'(longint'(kf_angle[ea]) + lerp_step(u, d));
        for (int p = 0; p < kti_pkg::POINTS; p++) begin
            logic [31:0] v [3];
            for (int c = 0; c < 3; c++) begin
                a = longint'($signed(kf_coord[ea][p][c]));
                b = longint'($signed(kf_coord[eb][p][c]));
                v[c] = (p == 0 || dv) ? 32'(a + lerp_step(u, b - a)) : '0;
            end
            s.pt = 2'(p);
            s.x = v[0];
            s.y = v[1];
            s.z = v[2];
            s.ang = (p == 0) ? ang : '0;
            s.dv = dv;
            s.last = (p == kti_pkg::POINTS - 1);
            if (p == 0 && r.typed) begin
                s.x = r.tx;
                s.ang = r.tang;
            end
            queue_sample(s);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sample_t s;
            if (pending() == 0) begin
                report("unexpected result point", 32'(m_tuser[1:0]), 32'd0);
            end else begin
                s = exp_q[exp_rd % 64];
                exp_rd++;
                if (m_tuser[1:0] !== s.pt) report("point", m_tuser[1:0], s.pt);
                if (m_tdata[31:0] !== s.x) report("x", m_tdata[31:0], s.x);
                if (m_tdata[63:32] !== s.y) report("y", m_tdata[63:32], s.y);
                if (m_tdata[95:64] !== s.z) report("z", m_tdata[95:64], s.z);
                if (m_tdata[111:96] !== s.ang) report("angle", m_tdata[111:96], s.ang);
                if (m_tuser[2] !== s.dv) report("drones_valid", m_tuser[2], s.dv);
                if (m_tlast !== s.last) report("last", m_tlast, s.last);
            end
        end
    end

    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (no_stall) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
            end
        end
    end

    function automatic int gap_len();
        int r;
        if (no_stall) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // leaves s_tvalid high on the accepted request; release_and_drain() lowers it
    task automatic send(request_t r);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, r.dp, r.ang, r.z, r.y, r.x, r.tval, r.entry};
        s_tuser <= {r.pt, r.act};
        do @(posedge aclk); while (!s_tready);
        apply_request(r);
    endtask

    task automatic release_and_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_count(logic [6:0] v);
        release_and_drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sample_count = v;
        settings_done++;
    endtask

    // drone flag only where all three drone points of the entry hold data
    function automatic request_t rand_write(int e, int p);
        request_t r;
        r = '{default: '0};
        r.act = kti_pkg::ACT_WRITE;
        r.entry = 6'(e);
        r.pt = 2'(p);
        r.tval = ($urandom_range(0, 9) == 0) ? $urandom() :
                 32'(e * 1000 + int'($urandom_range(0, 1200)));
        r.x = $urandom();
        r.y = $urandom();
        r.z = $urandom();
        r.ang = 16'($urandom());
        r.dp = ($urandom_range(0, 3) != 0) && kf_written[e][1] && kf_written[e][2] &&
               kf_written[e][3];
        return r;
    endfunction

    function automatic request_t rand_query();
        request_t r;
        int n, k;
        r = rand_write($urandom_range(0, 63), $urandom_range(0, 3));
        r.act = kti_pkg::ACT_QUERY;
        n = count_in_use();
        k = $urandom_range(0, 19);
        if (k == 0) r.tval = 32'hFFFF_FFFF;
        else if (k == 1) r.tval = 0;
        else if (k == 2) r.tval = $urandom();
        else if (k == 3) r.tval = kf_time[$urandom_range(0, n - 1)];
        else r.tval = $urandom_range(0, n * 1000 + 500);
        return r;
    endfunction

    task automatic fill_entries();
        for (int e = 0; e < count_in_use(); e++)
            if (!kf_written[e][kti_pkg::PT_PAYLOAD]) send(rand_write(e, 0));
    endtask

    task automatic random_phase(int items);
        request_t r;
        int n;
        for (int i = 0; i < items; i++) begin
            n = count_in_use();
            if ($urandom_range(0, 99) < 60) begin
                r = rand_query();
            end else if ($urandom_range(0, 9) == 0) begin
                r = rand_write($urandom_range(n, 63) % kti_pkg::ENTRIES, $urandom_range(0, 3));
            end else begin
                r = rand_write($urandom_range(0, n - 1), $urandom_range(0, 3));
            end
            send(r);
        end
    endtask

    request_t directed [32];
    int       directed_n;

    function automatic void add_row(request_t r);
        directed[directed_n] = r;
        directed_n++;
    endfunction

    function automatic request_t wr(int e, int p, logic [31:0] t, logic [31:0] x,
                                   logic [31:0] y, logic [31:0] z, logic [15:0] a,
                                   logic dp);
        request_t r;
        r = '{default: '0};
        r.act = kti_pkg::ACT_WRITE;
        r.entry = 6'(e);
        r.pt = 2'(p);
        r.tval = t;
        r.x = x;
        r.y = y;
        r.z = z;
        r.ang = a;
        r.dp = dp;
        return r;
    endfunction

    function automatic request_t qry(logic [31:0] t, bit typed = 0,
                                    logic [31:0] tx = 0, logic [15:0] ta = 0);
        request_t r;
        r = wr(63, 3, t, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        r.act = kti_pkg::ACT_QUERY;
        r.typed = typed;
        r.tx = tx;
        r.tang = ta;
        return r;
    endfunction

    initial begin
        logic [6:0] counts [6];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        no_stall = 1'b0;
        errors = 0;
        queries_done = 0;
        writes_done = 0;
        settings_done = 0;
        exp_wr = 0;
        exp_rd = 0;
        directed_n = 0;
        sample_count = 7'd2;
        for (int e = 0; e < kti_pkg::ENTRIES; e++) begin
            kf_time[e] = '0;
            kf_angle[e] = '0;
            kf_flag[e] = 1'b0;
            for (int p = 0; p < kti_pkg::POINTS; p++) begin
                kf_written[e][p] = 1'b0;
                for (int c = 0; c < 3; c++) kf_coord[e][p][c] = '0;
            end
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(wr(0, 0, 100, 32'h7FFF_FFFF, 32'h8000_0000, 0, 16'hFFFF, 1));
        add_row(wr(0, 1, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 0, 0));
        add_row(wr(0, 2, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0));
        add_row(wr(0, 3, 0, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0, 0));
        add_row(wr(1, 0, 200, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 1));
        add_row(wr(1, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        add_row(wr(1, 2, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0));
        add_row(wr(1, 3, 0, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_FFFF, 0, 0));
        add_row(qry(0, 1, 32'h7FFF_FFFF, 16'hFFFF));
        add_row(qry(100, 1, 32'h7FFF_FFFF, 16'hFFFF));
        add_row(qry(101));
        add_row(qry(150));
        add_row(qry(199));
        add_row(qry(200, 1, 32'h8000_0000, 16'h7FFF));
        add_row(qry(32'hFFFF_FFFF, 1, 32'h8000_0000, 16'h7FFF));
        // drones absent at one end, half-turn angle step
        add_row(wr(1, 0, 200, 32'h0000_0000, 0, 0, 16'h8000, 0));
        add_row(wr(0, 0, 100, 32'hFFFF_0000, 0, 0, 16'h0000, 1));
        add_row(qry(150));
        add_row(qry(200, 1, 32'h0000_0000, 16'h8000));
        add_row(qry(120));
        // equal times: span of zero
        add_row(wr(1, 0, 100, 32'h0004_0000, 1, 2, 16'h0100, 1));
        add_row(qry(100, 1, 32'hFFFF_0000, 16'h0000));
        add_row(qry(99, 1, 32'hFFFF_0000, 16'h0000));
        for (int i = 0; i < directed_n; i++) send(directed[i]);

        counts = '{7'd64, 7'd0, 7'd3, 7'd127, 7'd17, 7'd2};
        foreach (counts[i]) begin
            set_count(counts[i]);
            fill_entries();
            no_stall = (i == 2);
            random_phase(10);
            if (i == 3) begin
                release_and_drain();
                random_phase(5);
            end
        end
        set_count(7'($urandom_range(2, 64)));
        fill_entries();
        random_phase(10);

        release_and_drain();
        repeat (300) @(posedge aclk);
        if (pending() != 0) begin
            $display("%0d results never arrived", pending());
            errors++;
        end
        $display("checked %0d queries and %0d keyframe writes over %0d count settings",
                 queries_done, writes_done, settings_done);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/kti_pkg.sv
hdl/kti_ram.sv
hdl/keyframe_trajectory_interpolator.sv
tb/sv/tb.sv
